/* rtl/rfps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared widths, defaults and request codes for the rarest-first selector.
// ----------------------------------------------------------------------------
package rfps_pkg;

	localparam int REQ_W     = 2;
	localparam int PEER_ID_W = 6;
	localparam int PIECE_W   = 10;
	localparam int CNT_W     = 7;

	localparam int DEF_NUM_PIECES = 1024;
	localparam int DEF_NUM_PEERS  = 64;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENTRY  = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SELECT = 2'd2
	} req_t;

endpackage
`default_nettype wire

/* rtl/rarest_first_piece_selector_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rarest_first_piece_selector_unit
// Per-piece holder bitmap and holder count, with a rarest-piece scan per peer.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a request transfers on a rising edge with start high and
//    busy low. req_type selects bitfield entry, piece removal or selection.
//  - Result channel: a selection yields one result, shown for exactly one
//    cycle with done high (found, chosen_piece, chosen_holders). The receiver
//    cannot stall; the result must be taken in that cycle.
//  - Storage: one RAM word per piece holding {holder_count, holder_map}, with
//    registered read.
//  - Timing: a removal is a single write at the accept edge, busy stays low.
//    A bitfield entry with has_piece high is a read-modify-write: busy in S_UPD.
//    A selection sweeps the RAM once, one word per cycle through the single
//    read port, then shows its result in S_RESULT (a peer outside NUM_PEERS
//    goes straight there), and busy drops the cycle after done.
//  - Reset: arst_n clears control state, then a clearing pass writes zero to
//    every piece word, with busy high, before the first request is taken.
// ----------------------------------------------------------------------------
module rarest_first_piece_selector_unit #(
	parameter int NUM_PIECES = rfps_pkg::DEF_NUM_PIECES,
	parameter int NUM_PEERS  = rfps_pkg::DEF_NUM_PEERS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rfps_pkg::REQ_W-1:0]    req_type,
	input  wire logic [rfps_pkg::PEER_ID_W-1:0] peer_id,
	input  wire logic [rfps_pkg::PIECE_W-1:0]  piece_id,
	input  wire logic                          has_piece,
	output logic                               done,
	output logic                               found,
	output logic      [rfps_pkg::PIECE_W-1:0]  chosen_piece,
	output logic      [rfps_pkg::CNT_W-1:0]    chosen_holders
);

	import rfps_pkg::*;

	localparam int AW = $clog2(NUM_PIECES);
	localparam int PW = $clog2(NUM_PEERS);
	localparam int MW = NUM_PEERS + CNT_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_UPD,
		S_SCAN,
		S_RESULT
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [AW:0]     scan_q;
	logic            vld_s1;
	logic [AW-1:0]   idx_s1;
	logic [PW-1:0]   peer_q;
	logic [AW-1:0]   addr_q;
	logic            hit_q;
	logic [AW-1:0]   best_idx_q;
	logic [CNT_W-1:0] best_cnt_q;

	// RAM ports
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [MW-1:0]   ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [MW-1:0]   ram_rdata;

	// request decode
	logic            accept;
	logic            peer_ok;
	logic            piece_ok;
	logic [AW-1:0]   piece_addr;
	logic            is_entry;
	logic            is_remove;
	logic            is_select;

	// read word split
	logic [NUM_PEERS-1:0] rd_map;
	logic [CNT_W-1:0]     rd_cnt;
	logic [NUM_PEERS-1:0] set_map;
	logic                 rd_bit;
	logic                 scan_last;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign peer_ok    = 32'(peer_id) < NUM_PEERS;
	assign piece_ok   = 32'(piece_id) < NUM_PIECES;
	assign piece_addr = AW'(piece_id);
	assign is_entry   = (req_type == REQ_ENTRY);
	assign is_remove  = (req_type == REQ_REMOVE);
	assign is_select  = (req_type == REQ_SELECT);

	assign rd_map    = ram_rdata[NUM_PEERS-1:0];
	assign rd_cnt    = ram_rdata[NUM_PEERS +: CNT_W];
	assign rd_bit    = rd_map[peer_q];
	assign scan_last = (scan_q == (AW+1)'(NUM_PIECES));

	always_comb begin
		set_map         = rd_map;
		set_map[peer_q] = 1'b1;
	end

	// write port: clearing pass, entry write-back, or removal at accept
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_UPD: begin
				// mark only once; count follows the first mark
				ram_we    = !rd_bit;
				ram_wdata = {rd_cnt + CNT_W'(1), set_map};
			end
			S_IDLE: begin
				ram_we    = accept && is_remove && piece_ok;
				ram_waddr = piece_addr;
			end
			S_SCAN, S_RESULT: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = (state_q == S_SCAN) ? scan_q[AW-1:0] : piece_addr;

	rfps_ram #(
		.WIDTH (MW),
		.DEPTH (NUM_PIECES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			scan_q     <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			peer_q     <= '0;
			addr_q     <= '0;
			hit_q      <= 1'b0;
			best_idx_q <= '0;
			best_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_PIECES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						peer_q <= peer_id[PW-1:0];
						addr_q <= piece_addr;
						if (is_entry && has_piece && peer_ok && piece_ok) begin
							state_q <= S_UPD;
						end else if (is_select) begin
							hit_q      <= 1'b0;
							best_idx_q <= '0;
							best_cnt_q <= '0;
							scan_q     <= '0;
							vld_s1     <= 1'b0;
							state_q    <= peer_ok ? S_SCAN : S_RESULT;
						end
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					// compare the word that came back for the previous address
					if (vld_s1 && rd_bit && (!hit_q || rd_cnt < best_cnt_q)) begin
						hit_q      <= 1'b1;
						best_idx_q <= idx_s1;
						best_cnt_q <= rd_cnt;
					end
					if (scan_last) begin
						vld_s1  <= 1'b0;
						state_q <= S_RESULT;
					end else begin
						vld_s1 <= 1'b1;
						idx_s1 <= scan_q[AW-1:0];
						scan_q <= scan_q + (AW+1)'(1);
					end
				end
				S_RESULT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = (state_q == S_RESULT);
	assign found          = hit_q;
	assign chosen_piece   = PIECE_W'(best_idx_q);
	assign chosen_holders = best_cnt_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_sel_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_SELECT) |=> busy)
		else $error("select transfer did not make the unit busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (chosen_piece == '0 && chosen_holders == '0))
		else $error("empty result carries nonzero fields");

	a_found_held: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (chosen_holders != '0))
		else $error("chosen piece reports no holders");

endmodule
`default_nettype wire

/* rtl/rfps_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rfps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rfps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* sim/rarest_first_piece_selector_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarest_first_piece_selector_unit_tb
// Self-checking bench for the rarest-first selector. A scoreboard keeps its own
// copy of the holder maps and counts, predicts each selection at the transfer
// of the request, and compares every done strobe field by field. Directed
// cases come first, then a swarm that saturates one piece, then random swarm
// traffic built from peers announcing bitfields, selections and removals.
// ----------------------------------------------------------------------------
module rarest_first_piece_selector_unit_tb;
	import rfps_pkg::*;

	localparam int NUM_PIECES = DEF_NUM_PIECES;
	localparam int NUM_PEERS  = DEF_NUM_PEERS;

	// Request code the block has no use for; it must be dropped silently.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam int TOTAL_ITEMS = 580;
	localparam int POOL_SIZE   = 8;
	localparam int MAX_GAP     = 11;
	// Slowest legal run: ~580 selections, each a full sweep of NUM_PIECES words,
	// plus gaps and the clearing pass after reset. The limit is several times that.
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int SETTLE_CYCLES = NUM_PIECES + 16;

	typedef struct packed {
		logic               found;
		logic [PIECE_W-1:0] piece;
		logic [CNT_W-1:0]   holders;
	} pick_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [REQ_W-1:0]     req_type;
	logic [PEER_ID_W-1:0] peer_id;
	logic [PIECE_W-1:0]   piece_id;
	logic                 has_piece;
	logic                 done;
	logic                 found;
	logic [PIECE_W-1:0]   chosen_piece;
	logic [CNT_W-1:0]     chosen_holders;

	// Scoreboard copy of the piece store.
	logic [NUM_PEERS-1:0] holder_bits  [NUM_PIECES];
	logic [CNT_W-1:0]     holder_tally [NUM_PIECES];
	pick_t                expected_picks [$];

	int          mismatches = 0;
	int          sent_items = 0;
	int unsigned cycle_count = 0;
	bit          no_idle = 1'b0;

	// Working set for random traffic: a few hot pieces and recently active
	// peers, so selections land on peers that actually hold something.
	logic [PIECE_W-1:0]   piece_pool   [POOL_SIZE];
	logic [PEER_ID_W-1:0] recent_peers [POOL_SIZE];

	rarest_first_piece_selector_unit #(
		.NUM_PIECES(NUM_PIECES),
		.NUM_PEERS (NUM_PEERS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.peer_id       (peer_id),
		.piece_id      (piece_id),
		.has_piece     (has_piece),
		.done          (done),
		.found         (found),
		.chosen_piece  (chosen_piece),
		.chosen_holders(chosen_holders)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Rarest piece held by a peer: smallest count, lowest index on ties.
	function automatic pick_t rarest_pick(logic [PEER_ID_W-1:0] peer);
		pick_t best;
		best = '0;
		if (peer < NUM_PEERS) begin
			for (int i = 0; i < NUM_PIECES; i++) begin
				if (holder_bits[i][peer] &&
						(!best.found || holder_tally[i] < best.holders)) begin
					best.found   = 1'b1;
					best.piece   = PIECE_W'(i);
					best.holders = holder_tally[i];
				end
			end
		end
		return best;
	endfunction

	// Apply one transferred request to the scoreboard copy.
	task automatic track_request(logic [REQ_W-1:0] kind, logic [PEER_ID_W-1:0] peer,
			logic [PIECE_W-1:0] piece, logic has);
		case (kind)
			REQ_ENTRY: begin
				// marks are sticky; a repeat entry leaves the count alone
				if (has && peer < NUM_PEERS && piece < NUM_PIECES &&
						!holder_bits[piece][peer]) begin
					holder_bits[piece][peer] = 1'b1;
					holder_tally[piece]      = holder_tally[piece] + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (piece < NUM_PIECES) begin
					holder_bits[piece]  = '0;
					holder_tally[piece] = '0;
				end
			end
			REQ_SELECT: expected_picks.push_back(rarest_pick(peer));
			default: ;
		endcase
	endtask

	// One request transfer. Called right after a rising edge; returns right
	// after the edge that took the request. start is written once per step,
	// so back-to-back transfers keep it high without a glitch.
	task automatic send_req(logic [REQ_W-1:0] kind, logic [PEER_ID_W-1:0] peer,
			logic [PIECE_W-1:0] piece, logic has);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			// idle: fields carry junk the block must not act on
			start       <= 1'b0;
			req_type    <= REQ_W'($urandom_range(0, 3));
			peer_id     <= PEER_ID_W'($urandom_range(0, NUM_PEERS - 1));
			piece_id    <= PIECE_W'($urandom_range(0, NUM_PIECES - 1));
			has_piece   <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= kind;
		peer_id     <= peer;
		piece_id    <= piece;
		has_piece   <= has;
		@(posedge clk);
		while (busy) @(posedge clk);
		track_request(kind, peer, piece, has);
		if (!(kind == REQ_UNUSED || (kind == REQ_ENTRY && !has)))
			sent_items++;
	endtask

	task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
	endtask

	// Result checker: done is sampled at the edge closing its cycle.
	always @(posedge clk) begin : result_check
		pick_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_picks.size() == 0) begin
				log_mismatch("unrequested result (found)", 0, found);
			end else begin
				want = expected_picks.pop_front();
				if (found !== want.found)
					log_mismatch("found", want.found, found);
				if (chosen_piece !== want.piece)
					log_mismatch("chosen_piece", want.piece, chosen_piece);
				if (chosen_holders !== want.holders)
					log_mismatch("chosen_holders", want.holders, chosen_holders);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Fresh store: no peer holds anything.
	task automatic test_empty_select();
		send_req(REQ_SELECT, 6'd0, 10'd0, 1'b0);
		send_req(REQ_SELECT, 6'd63, 10'd1023, 1'b1);
	endtask

	// has_piece low and the unused code are dropped; a repeated mark does
	// not bump the count.
	task automatic test_entry_rules();
		send_req(REQ_ENTRY, 6'd5, 10'd10, 1'b0);
		send_req(REQ_UNUSED, 6'd5, 10'd12, 1'b1);
		send_req(REQ_ENTRY, 6'd5, 10'd10, 1'b1);
		send_req(REQ_ENTRY, 6'd5, 10'd10, 1'b1);
		send_req(REQ_SELECT, 6'd5, 10'd12, 1'b1);
	endtask

	// Equal counts go to the lower index; a rarer piece wins over both.
	task automatic test_ties_and_rarity();
		send_req(REQ_ENTRY, 6'd9, 10'd10, 1'b1);
		send_req(REQ_ENTRY, 6'd5, 10'd1023, 1'b1);
		send_req(REQ_ENTRY, 6'd63, 10'd1023, 1'b1);
		send_req(REQ_SELECT, 6'd5, 10'd0, 1'b0);
		send_req(REQ_ENTRY, 6'd63, 10'd0, 1'b1);
		send_req(REQ_SELECT, 6'd63, 10'd511, 1'b0);
	endtask

	// After the rarest piece is removed the next rarest is picked; once all
	// are gone the answer is none. Removing an untracked piece is harmless.
	task automatic test_removal();
		send_req(REQ_REMOVE, 6'd0, 10'd10, 1'b0);
		send_req(REQ_SELECT, 6'd5, 10'd10, 1'b0);
		send_req(REQ_REMOVE, 6'd0, 10'd1023, 1'b0);
		send_req(REQ_SELECT, 6'd63, 10'd1023, 1'b1);
		send_req(REQ_REMOVE, 6'd63, 10'd0, 1'b1);
		send_req(REQ_SELECT, 6'd63, 10'd0, 1'b1);
		send_req(REQ_REMOVE, 6'd0, 10'd512, 1'b1);
	endtask

	// Every peer announces one piece in shuffled order, driving the count to
	// its ceiling. That piece seeds the hot pool for the random phase.
	task automatic test_swarm_saturation();
		logic [PEER_ID_W-1:0] order [NUM_PEERS];
		logic [PEER_ID_W-1:0] tmp;
		int                   j;
		foreach (piece_pool[i])
			piece_pool[i] = PIECE_W'($urandom_range(0, NUM_PIECES - 1));
		foreach (recent_peers[i])
			recent_peers[i] = PEER_ID_W'($urandom_range(0, NUM_PEERS - 1));
		foreach (order[i])
			order[i] = PEER_ID_W'(i);
		for (int i = NUM_PEERS - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		no_idle = 1'b1;
		foreach (order[i])
			send_req(REQ_ENTRY, order[i], piece_pool[0], 1'b1);
		no_idle = 1'b0;
		send_req(REQ_SELECT, order[0], piece_pool[1], 1'b1);
	endtask

	// Random swarm: bitfield bursts on hot pieces, selections mostly for
	// active peers, completions that rotate the pool, short swarms, noise.
	task automatic test_random_traffic();
		int                   scenario;
		int                   burst;
		int                   slot;
		logic [PEER_ID_W-1:0] peer;
		logic [PIECE_W-1:0]   piece;
		while (sent_items < TOTAL_ITEMS) begin
			no_idle  = ($urandom_range(0, 3) == 0);
			scenario = $urandom_range(0, 99);
			if (scenario < 42) begin
				slot               = $urandom_range(0, POOL_SIZE - 1);
				peer               = PEER_ID_W'($urandom_range(0, NUM_PEERS - 1));
				recent_peers[slot] = peer;
				burst              = $urandom_range(1, 6);
				repeat (burst)
					send_req(REQ_ENTRY, peer, piece_pool[$urandom_range(0, POOL_SIZE - 1)],
						1'($urandom_range(0, 9) != 0));
			end else if (scenario < 77) begin
				if ($urandom_range(0, 4) == 0)
					peer = PEER_ID_W'($urandom_range(0, NUM_PEERS - 1));
				else
					peer = recent_peers[$urandom_range(0, POOL_SIZE - 1)];
				send_req(REQ_SELECT, peer, PIECE_W'($urandom_range(0, NUM_PIECES - 1)),
					1'($urandom_range(0, 1)));
			end else if (scenario < 86) begin
				// piece finished downloading; a new one becomes hot
				slot = $urandom_range(0, POOL_SIZE - 1);
				send_req(REQ_REMOVE, PEER_ID_W'($urandom_range(0, NUM_PEERS - 1)),
					piece_pool[slot], 1'($urandom_range(0, 1)));
				piece_pool[slot] = PIECE_W'($urandom_range(0, NUM_PIECES - 1));
			end else if (scenario < 89) begin
				// run of consecutive peers (wrapping) joining one piece
				piece = piece_pool[$urandom_range(0, POOL_SIZE - 1)];
				peer  = PEER_ID_W'($urandom_range(0, NUM_PEERS - 1));
				burst = $urandom_range(8, 40);
				repeat (burst) begin
					send_req(REQ_ENTRY, peer, piece, 1'b1);
					peer = peer + 1'b1;
				end
			end else begin
				peer  = PEER_ID_W'($urandom_range(0, NUM_PEERS - 1));
				piece = PIECE_W'($urandom_range(0, NUM_PIECES - 1));
				case ($urandom_range(0, 3))
					0: send_req(REQ_UNUSED, peer, piece, 1'($urandom_range(0, 1)));
					1: send_req(REQ_ENTRY, peer, piece, 1'b0);
					2: send_req(REQ_ENTRY, peer, piece, 1'b1);
					default: send_req(REQ_REMOVE, peer, piece, 1'($urandom_range(0, 1)));
				endcase
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = REQ_ENTRY;
		peer_id     = '0;
		piece_id    = '0;
		has_piece   = 1'b0;
		foreach (holder_bits[i]) begin
			holder_bits[i]  = '0;
			holder_tally[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the clearing pass holds busy high; send_req simply waits it out
		test_empty_select();
		test_entry_rules();
		test_ties_and_rarity();
		test_removal();
		test_swarm_saturation();
		test_random_traffic();

		start <= 1'b0;
		while (expected_picks.size() != 0) @(posedge clk);
		// any stray strobe after the last selection gets caught here
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
